@@ design/pfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

    // Parameter defaults.
    localparam int COUNT_BITS_DEF  = 12;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VREF       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_INT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_INT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_PROP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_SCALE = 3'd5;

    // Register reset values.
    localparam logic [31:0] PERIOD_RST     = 32'd333;
    localparam logic [31:0] VREF_RST       = 32'd2688;
    localparam logic [31:0] OUTER_INT_RST  = 32'd9320;
    localparam logic [31:0] INNER_INT_RST  = 32'd950612;
    localparam logic [31:0] INNER_PROP_RST = 32'd5033165;
    localparam logic [31:0] DUTY_SCALE_RST = 32'd2182349;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Wide signed intermediate: a 64-bit product plus sign and headroom.
    localparam int TERM_W = 66;

    typedef logic signed [TERM_W-1:0] t_term;

    typedef struct packed {
        logic [31:0] outer_int;
        logic [31:0] inner_int;
        logic [31:0] inner_prop;
        logic [31:0] duty_scale;
    } t_gains;

    typedef struct packed {
        logic sample;
        logic period_end;
    } t_job_ctl;

    typedef struct packed {
        logic busy;
        logic pop_sample;
    } t_back_stat;

    function automatic logic signed [31:0] sat32(input t_term x);
        logic [TERM_W-32:0] hi;
        hi = x[TERM_W-1:31];
        if ((&hi) || (~|hi)) begin
            return x[31:0];
        end else if (x[TERM_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/pfc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pfc_in_if #(
    parameter int SAMPLE_BITS = pfc_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] line_voltage;
    logic signed [SAMPLE_BITS-1:0] inductor_current;
    logic signed [SAMPLE_BITS-1:0] output_voltage;

    modport source (
        output valid, line_voltage, inductor_current, output_voltage,
        input  ready
    );
    modport sink (
        input  valid, line_voltage, inductor_current, output_voltage,
        output ready
    );
endinterface

interface pfc_out_if #(
    parameter int COUNT_BITS = pfc_pkg::COUNT_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic                       gate_on;
    logic signed [31:0]         current_ref;
    logic signed [COUNT_BITS:0] pulse_width;

    modport source (
        output valid, gate_on, current_ref, pulse_width,
        input  ready
    );
    modport sink (
        input  valid, gate_on, current_ref, pulse_width,
        output ready
    );
endinterface

interface pfc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pfc_pkg::CFG_IDX_W-1:0]    index;
    logic [pfc_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

@@ design/pfc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfc_front #(
    parameter int COUNT_BITS  = pfc_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = pfc_pkg::SAMPLE_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [COUNT_BITS-1:0] i_period,
    pfc_in_if.sink                i_in,
    input  wire                   i_q_ready,
    output logic                  o_q_push,
    output logic [$bits(pfc_pkg::t_job_ctl)+COUNT_BITS+3*SAMPLE_BITS-1:0] o_q_data
);

    logic [COUNT_BITS-1:0] r_tick;
    logic [COUNT_BITS-1:0] n_tick;
    logic                  r_first;
    logic [COUNT_BITS-1:0] tick_now;
    pfc_pkg::t_job_ctl     ctl;

    assign i_in.ready = i_q_ready;
    assign o_q_push   = i_in.valid & i_q_ready;

    // A period ends when the count reaches the period, or has passed it after
    // the period register was lowered.
    always_comb begin
        ctl.period_end = (r_tick >= i_period);
        ctl.sample     = ctl.period_end | r_first;
        tick_now       = ctl.period_end ? '0 : r_tick;
        n_tick         = tick_now + COUNT_BITS'(1);
    end

    assign o_q_data = {ctl, tick_now, i_in.line_voltage, i_in.inductor_current,
                       i_in.output_voltage};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_first <= 1'b1;
        end else if (o_q_push) begin
            r_tick  <= n_tick;
            r_first <= 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ design/pfc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfc_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = pfc_pkg::QUEUE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [DATA_W-1:0] i_data,
    output logic              o_ready,
    input  wire               i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_data [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_data[r_rd_ptr];
    assign push_ok = i_push & o_ready;
    assign pop_ok  = i_pop & o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end else begin
            return p + PTR_W'(1);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop_ok) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/pfc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfc_back #(
    parameter int COUNT_BITS  = pfc_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = pfc_pkg::SAMPLE_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire        [COUNT_BITS-1:0]   i_period,
    input  wire signed [SAMPLE_BITS-1:0]  i_vref,
    input  pfc_pkg::t_gains               i_gains,
    input  wire                           i_q_valid,
    input  wire [$bits(pfc_pkg::t_job_ctl)+COUNT_BITS+3*SAMPLE_BITS-1:0] i_q_data,
    output logic                          o_q_pop,
    output pfc_pkg::t_back_stat           o_stat,
    pfc_out_if.source                     o_out
);

    localparam int CTL_W = $bits(pfc_pkg::t_job_ctl);
    localparam int JOB_W = CTL_W + COUNT_BITS + 3 * SAMPLE_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ERRV = 3'd1;
    localparam logic [2:0] S_OP   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_ERRI = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [2:0] STEP_VINT = 3'd0;
    localparam logic [2:0] STEP_IREF = 3'd1;
    localparam logic [2:0] STEP_CINT = 3'd2;
    localparam logic [2:0] STEP_PROP = 3'd3;
    localparam logic [2:0] STEP_DUTY = 3'd4;

    // Job fields.
    pfc_pkg::t_job_ctl              q_ctl;
    logic [COUNT_BITS-1:0]          q_tick;
    logic signed [SAMPLE_BITS-1:0]  q_vline;
    logic signed [SAMPLE_BITS-1:0]  q_il;
    logic signed [SAMPLE_BITS-1:0]  q_vo;

    assign q_ctl   = pfc_pkg::t_job_ctl'(i_q_data[JOB_W-1 -: CTL_W]);
    assign q_tick  = i_q_data[3*SAMPLE_BITS +: COUNT_BITS];
    assign q_vline = i_q_data[2*SAMPLE_BITS +: SAMPLE_BITS];
    assign q_il    = i_q_data[SAMPLE_BITS +: SAMPLE_BITS];
    assign q_vo    = i_q_data[0 +: SAMPLE_BITS];

    // Control and loop state.
    logic [2:0]                 r_state, n_state;
    logic [2:0]                 r_step, n_step;
    logic signed [COUNT_BITS:0] r_width_active, n_width_active;
    logic signed [COUNT_BITS:0] r_width_next, n_width_next;
    logic signed [31:0]         r_vint, n_vint;
    logic signed [31:0]         r_cint, n_cint;
    logic signed [31:0]         r_vprev, n_vprev;
    logic signed [31:0]         r_cprev, n_cprev;
    logic signed [31:0]         r_cref, n_cref;
    logic                       r_out_valid, n_out_valid;

    // Working registers.
    logic [COUNT_BITS-1:0]          r_tick, n_tick;
    logic signed [SAMPLE_BITS-1:0]  r_vline, n_vline;
    logic signed [SAMPLE_BITS-1:0]  r_il, n_il;
    logic signed [SAMPLE_BITS-1:0]  r_vo, n_vo;
    logic signed [31:0]             r_errv, n_errv;
    logic signed [31:0]             r_erri, n_erri;
    logic signed [31:0]             r_vm, n_vm;
    logic [31:0]                    r_mag, n_mag;
    logic                           r_neg, n_neg;
    logic [31:0]                    r_gain, n_gain;
    logic [63:0]                    r_prod, n_prod;
    logic                           r_out_gate, n_out_gate;
    logic signed [31:0]             r_out_cref, n_out_cref;
    logic signed [COUNT_BITS:0]     r_out_width, n_out_width;

    logic                       out_free;
    logic                       pop;
    logic signed [COUNT_BITS:0] width_now;
    pfc_pkg::t_term             vline_ext;
    pfc_pkg::t_term             va_ext;
    logic signed [31:0]         opa;
    logic [31:0]                opg;
    logic [63:0]                prod_sh;
    pfc_pkg::t_term             term;
    pfc_pkg::t_term             width_hi;
    pfc_pkg::t_term             width_cl;

    assign out_free = !r_out_valid || o_out.ready;

    // Operand and gain for the shared multiplier, and the scaled product.
    always_comb begin
        vline_ext = pfc_pkg::t_term'(r_vline);
        va_ext    = vline_ext[pfc_pkg::TERM_W-1] ? -vline_ext : vline_ext;
        case (r_step)
            STEP_VINT: begin
                opa = pfc_pkg::sat32(pfc_pkg::t_term'(r_errv) + pfc_pkg::t_term'(r_vprev));
                opg = i_gains.outer_int;
            end
            STEP_IREF: begin
                opa = pfc_pkg::sat32(pfc_pkg::t_term'(r_errv) + pfc_pkg::t_term'(r_vint));
                opg = va_ext[31:0];
            end
            STEP_CINT: begin
                opa = pfc_pkg::sat32(pfc_pkg::t_term'(r_erri) + pfc_pkg::t_term'(r_cprev));
                opg = i_gains.inner_int;
            end
            STEP_PROP: begin
                opa = r_erri;
                opg = i_gains.inner_prop;
            end
            default: begin
                opa = r_vm;
                opg = i_gains.duty_scale;
            end
        endcase
        case (r_step)
            STEP_IREF: prod_sh = r_prod >> 8;
            STEP_DUTY: prod_sh = r_prod >> 32;
            default:   prod_sh = r_prod >> 24;
        endcase
        // The magnitude is multiplied and the sign put back, which truncates
        // the scaled product toward zero.
        term = r_neg ? -pfc_pkg::t_term'({2'b00, prod_sh})
                     : pfc_pkg::t_term'({2'b00, prod_sh});
        width_hi = pfc_pkg::t_term'($signed({1'b0, i_period}));
        if (term > width_hi) begin
            width_cl = width_hi;
        end else if (term < pfc_pkg::t_term'(-1)) begin
            width_cl = pfc_pkg::t_term'(-1);
        end else begin
            width_cl = term;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        n_width_active = r_width_active;
        n_width_next   = r_width_next;
        n_vint         = r_vint;
        n_cint         = r_cint;
        n_vprev        = r_vprev;
        n_cprev        = r_cprev;
        n_cref         = r_cref;
        n_tick         = r_tick;
        n_vline        = r_vline;
        n_il           = r_il;
        n_vo           = r_vo;
        n_errv         = r_errv;
        n_erri         = r_erri;
        n_vm           = r_vm;
        n_mag          = r_mag;
        n_neg          = r_neg;
        n_gain         = r_gain;
        n_prod         = r_prod;
        n_out_gate     = r_out_gate;
        n_out_cref     = r_out_cref;
        n_out_width    = r_out_width;
        n_out_valid    = r_out_valid && !o_out.ready;
        pop            = 1'b0;
        width_now      = q_ctl.period_end ? r_width_next : r_width_active;

        unique case (r_state)
            S_IDLE: begin
                // A sampling job may start while the output register is still
                // full; a plain tick goes straight to the output register.
                if (i_q_valid && (q_ctl.sample || out_free)) begin
                    pop            = 1'b1;
                    n_width_active = width_now;
                    n_tick         = q_tick;
                    if (q_ctl.sample) begin
                        n_vline = q_vline;
                        n_il    = q_il;
                        n_vo    = q_vo;
                        n_state = S_ERRV;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_gate  = ($signed({1'b0, q_tick}) <= width_now);
                        n_out_cref  = r_cref;
                        n_out_width = width_now;
                    end
                end
            end
            S_ERRV: begin
                n_errv  = pfc_pkg::sat32((pfc_pkg::t_term'(i_vref) -
                                          pfc_pkg::t_term'(r_vo)) <<< 8);
                n_step  = STEP_VINT;
                n_state = S_OP;
            end
            S_OP: begin
                n_neg   = opa[31];
                n_mag   = opa[31] ? 32'(-opa) : 32'(opa);
                n_gain  = opg;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = {32'b0, r_mag} * {32'b0, r_gain};
                n_state = S_ACC;
            end
            S_ACC: begin
                case (r_step)
                    STEP_VINT: begin
                        n_vint  = pfc_pkg::sat32(pfc_pkg::t_term'(r_vint) + term);
                        n_step  = STEP_IREF;
                        n_state = S_OP;
                    end
                    STEP_IREF: begin
                        n_cref  = pfc_pkg::sat32(term);
                        n_state = S_ERRI;
                    end
                    STEP_CINT: begin
                        n_cint  = pfc_pkg::sat32(pfc_pkg::t_term'(r_cint) + term);
                        n_step  = STEP_PROP;
                        n_state = S_OP;
                    end
                    STEP_PROP: begin
                        n_vm    = pfc_pkg::sat32(pfc_pkg::t_term'(r_cint) + term);
                        n_step  = STEP_DUTY;
                        n_state = S_OP;
                    end
                    default: begin
                        n_width_next = width_cl[COUNT_BITS:0];
                        n_vprev      = r_errv;
                        n_cprev      = r_erri;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_ERRI: begin
                n_erri  = pfc_pkg::sat32(pfc_pkg::t_term'(r_cref) -
                                         (pfc_pkg::t_term'(r_il) <<< 8));
                n_step  = STEP_CINT;
                n_state = S_OP;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_gate  = ($signed({1'b0, r_tick}) <= r_width_active);
                    n_out_cref  = r_cref;
                    n_out_width = r_width_active;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= STEP_VINT;
            r_width_active <= '0;
            r_width_next   <= '0;
            r_vint         <= '0;
            r_cint         <= '0;
            r_vprev        <= '0;
            r_cprev        <= '0;
            r_cref         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_step         <= n_step;
            r_width_active <= n_width_active;
            r_width_next   <= n_width_next;
            r_vint         <= n_vint;
            r_cint         <= n_cint;
            r_vprev        <= n_vprev;
            r_cprev        <= n_cprev;
            r_cref         <= n_cref;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick      <= n_tick;
        r_vline     <= n_vline;
        r_il        <= n_il;
        r_vo        <= n_vo;
        r_errv      <= n_errv;
        r_erri      <= n_erri;
        r_vm        <= n_vm;
        r_mag       <= n_mag;
        r_neg       <= n_neg;
        r_gain      <= n_gain;
        r_prod      <= n_prod;
        r_out_gate  <= n_out_gate;
        r_out_cref  <= n_out_cref;
        r_out_width <= n_out_width;
    end

    assign o_q_pop           = pop;
    assign o_stat.busy       = (r_state != S_IDLE);
    assign o_stat.pop_sample = pop & q_ctl.sample;

    assign o_out.valid       = r_out_valid;
    assign o_out.gate_on     = r_out_gate;
    assign o_out.current_ref = r_out_cref;
    assign o_out.pulse_width = r_out_width;

endmodule

`default_nettype wire

@@ design/pfc_dual_pi_pwm_controller_top.sv @@
// A plain tick passes through the job queue into the output register.
// A tick that starts a period runs both PI loops through one shared 32x32
// multiplier in five operand/multiply/accumulate rounds.
// Input is taken every cycle while the two-entry job queue has room.
// Synchronous active-low reset: tick count and loop state zero, first tick samples,
// configuration registers return to their default values.
`timescale 1ns / 1ps
`default_nettype none

module pfc_dual_pi_pwm_controller_top #(
    parameter int COUNT_BITS  = pfc_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = pfc_pkg::SAMPLE_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pfc_in_if.sink     i_in,
    pfc_out_if.source  o_out,
    pfc_cfg_if.sink    i_cfg
);

    localparam int CTL_W = $bits(pfc_pkg::t_job_ctl);
    localparam int JOB_W = CTL_W + COUNT_BITS + 3 * SAMPLE_BITS;

    logic [COUNT_BITS-1:0]         r_period;
    logic signed [SAMPLE_BITS-1:0] r_vref;
    pfc_pkg::t_gains               r_gains;

    logic                q_push;
    logic [JOB_W-1:0]    q_push_data;
    logic                q_ready;
    logic                q_pop;
    logic                q_valid;
    logic [JOB_W-1:0]    q_data;
    pfc_pkg::t_back_stat back_stat;
    pfc_pkg::t_job_ctl   push_ctl;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period           <= COUNT_BITS'(pfc_pkg::PERIOD_RST);
            r_vref             <= SAMPLE_BITS'(pfc_pkg::VREF_RST);
            r_gains.outer_int  <= pfc_pkg::OUTER_INT_RST;
            r_gains.inner_int  <= pfc_pkg::INNER_INT_RST;
            r_gains.inner_prop <= pfc_pkg::INNER_PROP_RST;
            r_gains.duty_scale <= pfc_pkg::DUTY_SCALE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pfc_pkg::REG_PERIOD:     r_period           <= i_cfg.data[COUNT_BITS-1:0];
                pfc_pkg::REG_VREF:       r_vref             <= i_cfg.data[SAMPLE_BITS-1:0];
                pfc_pkg::REG_OUTER_INT:  r_gains.outer_int  <= i_cfg.data;
                pfc_pkg::REG_INNER_INT:  r_gains.inner_int  <= i_cfg.data;
                pfc_pkg::REG_INNER_PROP: r_gains.inner_prop <= i_cfg.data;
                pfc_pkg::REG_DUTY_SCALE: r_gains.duty_scale <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    pfc_front #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_period  (r_period),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_data  (q_push_data)
    );

    pfc_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (pfc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_push_data),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    pfc_back #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_period  (r_period),
        .i_vref    (r_vref),
        .i_gains   (r_gains),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_stat    (back_stat),
        .o_out     (o_out)
    );

    assign push_ctl = pfc_pkg::t_job_ctl'(q_push_data[JOB_W-1 -: CTL_W]);

    // The back end only takes a job that the queue holds.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("job popped from an empty queue");

    // A sampling job keeps the sequencer busy in the following cycle.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.pop_sample |=> back_stat.busy)
        else $error("sampling job did not start the loop sequencer");

    // No new job is taken while the loops are being computed.
    a_busy_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.busy |-> !q_pop)
        else $error("job popped while the sequencer is busy");

    // Every period end is classified as a sampling tick.
    a_end_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && push_ctl.period_end) |-> push_ctl.sample)
        else $error("period end queued without a sample");

endmodule

`default_nettype wire
